// File: src/rbr_pkg.sv
// Shared types, widths and helpers of the bilinear RGB resizer
package rbr_pkg;

  // Frame and arithmetic sizes
  localparam int MAX_SIDE   = 1024;
  localparam int FRAC_BITS  = 11;
  localparam int IN_COORD_W = 10;
  localparam int CFG_W      = 11;
  localparam int PIX_W      = 8;
  localparam int NCH        = 3;

  localparam int COORD_W = $clog2(MAX_SIDE);
  localparam int SIDE_W  = COORD_W + 1;
  localparam int SCALE_W = COORD_W + FRAC_BITS;
  localparam int DVD_W   = SIDE_W + FRAC_BITS;
  localparam int POS_W   = COORD_W + SCALE_W;
  localparam int IPOS_W  = POS_W - FRAC_BITS;
  localparam int ADDR_W  = 2 * COORD_W;
  localparam int T_W     = PIX_W + FRAC_BITS;
  localparam int Y_W     = T_W + FRAC_BITS;
  localparam int HALF    = 1 << (FRAC_BITS - 1);

  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [SIDE_W-1:0]    side_t;
  typedef logic [SCALE_W-1:0]   scale_t;
  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [IPOS_W-1:0]    ipos_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;
  typedef logic [PIX_W-1:0]     chan_t;
  typedef chan_t [NCH-1:0]      cvec_t;
  typedef logic [T_W-1:0]       tval_t;
  typedef tval_t [NCH-1:0]      tvec_t;
  typedef logic [Y_W-1:0]       yval_t;
  typedef yval_t [NCH-1:0]      yvec_t;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_DST_WIDTH,
    REG_DST_HEIGHT
  } cfg_idx_t;

  // Stored source pixel: red on top, blue at the bottom
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pix_t;

  typedef struct packed {
    logic                  kind;
    logic [IN_COORD_W-1:0] col;
    logic [IN_COORD_W-1:0] row;
    chan_t                 red_in;
    chan_t                 green_in;
    chan_t                 blue_in;
  } in_item_t;

  typedef struct packed {
    chan_t red_out;
    chan_t green_out;
    chan_t blue_out;
  } out_item_t;

  // Saturate a frame side to the supported range
  function automatic side_t sat_side(cfg_data_t v);
    if (32'(v) < 2) begin
      return side_t'(2);
    end else if (32'(v) > MAX_SIDE) begin
      return side_t'(MAX_SIDE);
    end else begin
      return side_t'(v);
    end
  endfunction

  // Last index along a side
  function automatic coord_t last_of(side_t s);
    side_t d;
    d = s - side_t'(1);
    return d[COORD_W-1:0];
  endfunction

  // Widen the three channels of a pixel to blend lanes
  function automatic tvec_t to_tvec(pix_t p);
    cvec_t c;
    tvec_t t;
    c = cvec_t'(p);
    for (int k = 0; k < NCH; k++) begin
      t[k] = tval_t'(c[k]);
    end
    return t;
  endfunction

endpackage

// File: src/rbr_ram.sv
// Generic single-port RAM with registered read
module rbr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, or read into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/rbr_div.sv
// Iterative restoring divider for the scale step, one quotient bit a cycle
module rbr_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start_i,
  input  logic [rbr_pkg::DVD_W-1:0] dividend_i,
  input  rbr_pkg::side_t           divisor_i,
  output logic                     done_o,
  output rbr_pkg::scale_t          quot_o
);
  import rbr_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  side_t            rem_r;
  side_t            dvs_r;
  logic [SIDE_W:0]  trial;
  logic [SIDE_W:0]  diff;
  logic             ge;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end

    // Load operands, then advance one bit a cycle
    if (start_i) begin
      quo_r <= dividend_i;
      rem_r <= '0;
      dvs_r <= divisor_i;
    end else if (run_r) begin
      rem_r <= ge ? diff[SIDE_W-1:0] : trial[SIDE_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign done_o = done_r;
  assign quot_o = quo_r[SCALE_W-1:0];

endmodule

// File: src/rbr_blend.sv
// Three-lane blend unit: (a << F) + f * (b - a), one lane per colour channel
module rbr_blend (
  input  rbr_pkg::tvec_t a_i,
  input  rbr_pkg::tvec_t b_i,
  input  rbr_pkg::frac_t f_i,
  output rbr_pkg::yvec_t y_o
);
  import rbr_pkg::*;

  localparam int PROD_W = FRAC_BITS + T_W + 2;

  typedef logic signed [T_W:0]      diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  diff_t diff [NCH];
  prod_t prod [NCH];
  prod_t base [NCH];
  prod_t sum  [NCH];

  // Blend each channel; the sum never goes negative
  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      diff[k] = $signed({1'b0, b_i[k]}) - $signed({1'b0, a_i[k]});
      prod[k] = $signed({1'b0, f_i}) * diff[k];
      base[k] = prod_t'({a_i[k], {FRAC_BITS{1'b0}}});
      sum[k]  = base[k] + prod[k];
      y_o[k]  = sum[k][Y_W-1:0];
    end
  end

endmodule

// File: src/rgb_bilinear_resize.sv
// Top level of the bilinear RGB resizer: frame store, sequencer and datapath
//
// A write word (kind 0) stores one source pixel: start is
// accepted whenever busy is low, so writes can follow one another every cycle.
// A request word (kind 1) keeps busy high until its result is ready: position
// arithmetic (S_POSX and S_POSY on the shared multiplier, then S_IDX), four
// reads through the single frame memory port plus one for the last read data,
// and three passes of the shared three-lane blend unit. The result is shown on
// out_item for exactly one cycle, marked by out_strobe, and must be taken then;
// the next word may be accepted in that same cycle. After reset and after any
// configuration write the first request also runs the two scale divisions on
// the shared bit-serial divider. The frame memory is not cleared: pixels read
// before they are written return whatever it holds.
module rgb_bilinear_resize (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  rbr_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_strobe,
  output rbr_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  rbr_pkg::cfg_data_t cfg_data
);
  import rbr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVX_GO,
    S_DIVX_WAIT,
    S_DIVY_GO,
    S_DIVY_WAIT,
    S_POSX,
    S_POSY,
    S_IDX,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_RD4,
    S_T2,
    S_V
  } state_t;

  typedef logic [POS_W:0] pose_t;
  typedef logic [T_W:0]   rsum_t;

  localparam pose_t HALF_P = pose_t'(HALF);
  localparam rsum_t HALF_T = rsum_t'(HALF);

  state_t    state_r, state_nxt;
  cfg_data_t src_w_r, src_h_r, dst_w_r, dst_h_r;
  side_t     sw, sh, dw, dh;
  coord_t    sw_m1, sh_m1, dw_m1, dh_m1;

  logic   accept, acc_wr, acc_req, wr_ok;
  coord_t col_sat, row_sat;

  scale_t sclx_r, scly_r;
  logic   scale_ok_r;
  coord_t col_r, row_r;
  logic   lc_r, lr_r;
  pos_t   posx_r, posy_r;
  coord_t ya_r, yb_r, xa_r, xb_r;
  frac_t  fx_r, fy_r;
  logic   rnd_r;
  pix_t   p00_r, p01_r, p10_r, p11_r;
  tvec_t  t1_r, t2_r;
  out_item_t out_item_r;
  logic      out_strobe_r;

  logic             div_start, div_done;
  logic [DVD_W-1:0] div_dvd;
  side_t            div_dvs;
  scale_t           div_quot;

  coord_t mul_n;
  scale_t mul_s;
  pos_t   mul_p;
  pose_t  mul_off, mul_sub;
  pos_t   pos_adj;

  ipos_t  ixr, iyr;
  coord_t ix, iy, ix2, iy2;

  tvec_t bl_a, bl_b, bl_t;
  frac_t bl_f;
  yvec_t bl_y;
  rsum_t [NCH-1:0] rs;
  cvec_t res_c;

  logic  ram_we;
  addr_t ram_addr;
  pix_t  ram_wdata, ram_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= cfg_data_t'(960);
      src_h_r <= cfg_data_t'(540);
      dst_w_r <= cfg_data_t'(960);
      dst_h_r <= cfg_data_t'(540);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_SRC_WIDTH:  src_w_r <= cfg_data;
        REG_SRC_HEIGHT: src_h_r <= cfg_data;
        REG_DST_WIDTH:  dst_w_r <= cfg_data;
        REG_DST_HEIGHT: dst_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective frame sizes and last indexes
  assign sw    = sat_side(src_w_r);
  assign sh    = sat_side(src_h_r);
  assign dw    = sat_side(dst_w_r);
  assign dh    = sat_side(dst_h_r);
  assign sw_m1 = last_of(sw);
  assign sh_m1 = last_of(sh);
  assign dw_m1 = last_of(dw);
  assign dh_m1 = last_of(dh);

  // Word acceptance; requests beyond the destination take its last pixel
  assign accept  = start && !busy;
  assign acc_wr  = accept && !in_item.kind;
  assign acc_req = accept && in_item.kind;
  assign wr_ok   = (32'(in_item.col) < MAX_SIDE) && (32'(in_item.row) < MAX_SIDE);
  assign col_sat = (32'(in_item.col) > 32'(dw_m1)) ? dw_m1 : coord_t'(in_item.col);
  assign row_sat = (32'(in_item.row) > 32'(dh_m1)) ? dh_m1 : coord_t'(in_item.row);

  // Shared scale divider
  assign div_start = (state_r == S_DIVX_GO) || (state_r == S_DIVY_GO);
  assign div_dvd   = (state_r == S_DIVY_GO) ? {sh, {FRAC_BITS{1'b0}}}
                                            : {sw, {FRAC_BITS{1'b0}}};
  assign div_dvs   = (state_r == S_DIVY_GO) ? dh : dw;

  rbr_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Shared position multiplier, with half-pixel offset clamped at zero inside
  always_comb begin
    if (state_r == S_POSY) begin
      mul_n = row_r;
      mul_s = scly_r;
    end else begin
      mul_n = col_r;
      mul_s = sclx_r;
    end
    mul_p   = pos_t'(mul_n) * pos_t'(mul_s);
    mul_off = {1'b0, mul_p} + pose_t'(mul_s >> 1);
    mul_sub = mul_off - HALF_P;
    if (lc_r || lr_r) begin
      pos_adj = mul_p;
    end else if (mul_off < HALF_P) begin
      pos_adj = '0;
    end else begin
      pos_adj = mul_sub[POS_W-1:0];
    end
  end

  // Integer neighbours, clamped to the source frame
  assign ixr = posx_r[POS_W-1:FRAC_BITS];
  assign iyr = posy_r[POS_W-1:FRAC_BITS];
  assign ix  = (ixr > ipos_t'(sw_m1)) ? sw_m1 : ixr[COORD_W-1:0];
  assign iy  = (iyr > ipos_t'(sh_m1)) ? sh_m1 : iyr[COORD_W-1:0];
  assign ix2 = (ix < sw_m1) ? ix + coord_t'(1) : ix;
  assign iy2 = (iy < sh_m1) ? iy + coord_t'(1) : iy;

  // Blend operands for the top pair, bottom pair and vertical pass
  always_comb begin
    case (state_r)
      S_RD4: begin
        bl_a = to_tvec(p00_r);
        bl_b = to_tvec(p01_r);
        bl_f = fx_r;
      end
      S_T2: begin
        bl_a = to_tvec(p10_r);
        bl_b = to_tvec(p11_r);
        bl_f = fx_r;
      end
      default: begin
        bl_a = t1_r;
        bl_b = t2_r;
        bl_f = fy_r;
      end
    endcase
  end

  rbr_blend u_blend (
    .a_i (bl_a),
    .b_i (bl_b),
    .f_i (bl_f),
    .y_o (bl_y)
  );

  // Narrow horizontal results; round and truncate the vertical result
  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      bl_t[k]  = bl_y[k][T_W-1:0];
      rs[k]    = {1'b0, bl_y[k][Y_W-1:FRAC_BITS]} + (rnd_r ? HALF_T : rsum_t'(0));
      res_c[k] = rs[k][FRAC_BITS+PIX_W-1:FRAC_BITS];
    end
  end

  // Frame memory port: writes when idle, four neighbour reads per request
  always_comb begin
    case (state_r)
      S_RD0:   ram_addr = {ya_r, xa_r};
      S_RD1:   ram_addr = {ya_r, xb_r};
      S_RD2:   ram_addr = {yb_r, xa_r};
      S_RD3:   ram_addr = {yb_r, xb_r};
      default: ram_addr = {coord_t'(in_item.row), coord_t'(in_item.col)};
    endcase
  end

  assign ram_we    = acc_wr && wr_ok;
  assign ram_wdata = '{red: in_item.red_in, green: in_item.green_in, blue: in_item.blue_in};

  rbr_ram #(
    .WIDTH ($bits(pix_t)),
    .DEPTH (1 << ADDR_W)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc_req) begin
          state_nxt = (scale_ok_r && !cfg_we) ? S_POSX : S_DIVX_GO;
        end
      end
      S_DIVX_GO:   state_nxt = S_DIVX_WAIT;
      S_DIVX_WAIT: if (div_done) state_nxt = S_DIVY_GO;
      S_DIVY_GO:   state_nxt = S_DIVY_WAIT;
      S_DIVY_WAIT: if (div_done) state_nxt = S_POSX;
      S_POSX:      state_nxt = S_POSY;
      S_POSY:      state_nxt = S_IDX;
      S_IDX:       state_nxt = S_RD0;
      S_RD0:       state_nxt = S_RD1;
      S_RD1:       state_nxt = S_RD2;
      S_RD2:       state_nxt = S_RD3;
      S_RD3:       state_nxt = S_RD4;
      S_RD4:       state_nxt = S_T2;
      S_T2:        state_nxt = S_V;
      S_V:         state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Hold state, result strobe and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scale_ok_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == S_V);
      if (cfg_we) begin
        scale_ok_r <= 1'b0;
      end else if ((state_r == S_DIVY_WAIT) && div_done) begin
        scale_ok_r <= 1'b1;
      end
    end

    if (acc_req) begin
      col_r <= col_sat;
      row_r <= row_sat;
      lc_r  <= (col_sat == dw_m1);
      lr_r  <= (row_sat == dh_m1);
    end

    case (state_r)
      S_DIVX_WAIT: if (div_done) sclx_r <= div_quot;
      S_DIVY_WAIT: if (div_done) scly_r <= div_quot;
      S_POSX:      posx_r <= pos_adj;
      S_POSY:      posy_r <= pos_adj;
      S_IDX: begin
        if (lc_r && lr_r) begin
          // corner: copy the last source pixel
          ya_r  <= sh_m1;
          yb_r  <= sh_m1;
          xa_r  <= sw_m1;
          xb_r  <= sw_m1;
          fx_r  <= '0;
          fy_r  <= '0;
          rnd_r <= 1'b0;
        end else if (lc_r) begin
          // last column: vertical blend only, truncated
          ya_r  <= iy;
          yb_r  <= iy2;
          xa_r  <= sw_m1;
          xb_r  <= sw_m1;
          fx_r  <= '0;
          fy_r  <= posy_r[FRAC_BITS-1:0];
          rnd_r <= 1'b0;
        end else if (lr_r) begin
          // last row: horizontal blend only, truncated
          ya_r  <= sh_m1;
          yb_r  <= sh_m1;
          xa_r  <= ix;
          xb_r  <= ix2;
          fx_r  <= posx_r[FRAC_BITS-1:0];
          fy_r  <= '0;
          rnd_r <= 1'b0;
        end else begin
          ya_r  <= iy;
          yb_r  <= iy2;
          xa_r  <= ix;
          xb_r  <= ix2;
          fx_r  <= posx_r[FRAC_BITS-1:0];
          fy_r  <= posy_r[FRAC_BITS-1:0];
          rnd_r <= 1'b1;
        end
      end
      S_RD1: p00_r <= ram_rdata;
      S_RD2: p01_r <= ram_rdata;
      S_RD3: p10_r <= ram_rdata;
      S_RD4: begin
        p11_r <= ram_rdata;
        t1_r  <= bl_t;
      end
      S_T2:  t2_r <= bl_t;
      S_V:   out_item_r <= out_item_t'(res_c);
      default: ;
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// File: dv/tb_rgb_bilinear_resize.sv
// Self-checking testbench for the bilinear RGB resizer: scoreboard, drivers and stimulus
`timescale 1ns / 1ps

import rbr_pkg::*;

localparam logic   KIND_WRITE   = 1'b0;
localparam logic   KIND_REQUEST = 1'b1;
localparam longint FRAC_ONE     = longint'(1) << FRAC_BITS;
localparam longint FRAC_MASK    = FRAC_ONE - 1;

// Keeps a copy of the source frame and the sizes, and predicts each resampled pixel
class resize_checker;
  pix_t      frame [MAX_SIDE*MAX_SIDE];
  cfg_data_t sizes [4];
  out_item_t pending_pixels [$];
  int        errors;

  function new();
    sizes[REG_SRC_WIDTH]  = cfg_data_t'(960);
    sizes[REG_SRC_HEIGHT] = cfg_data_t'(540);
    sizes[REG_DST_WIDTH]  = cfg_data_t'(960);
    sizes[REG_DST_HEIGHT] = cfg_data_t'(540);
    errors = 0;
  endfunction

  function void set_reg(cfg_idx_t idx, cfg_data_t v);
    sizes[idx] = v;
  endfunction

  // Side as the block uses it: saturated to 2..MAX_SIDE
  function int side_of(cfg_idx_t idx);
    int v;
    v = int'(sizes[idx]);
    if (v < 2) return 2;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  function cvec_t pixel_at(int r, int c);
    return cvec_t'(frame[r*MAX_SIDE + c]);
  endfunction

  // One-axis blend: ((a << F) + f*(b - a)) >> F
  function longint lerp(longint a, longint b, longint f);
    return (a * FRAC_ONE + f * (b - a)) >>> FRAC_BITS;
  endfunction

  function out_item_t resample(int c, int r);
    int     sw, sh, dw, dh, ix, iy, iy2, ix2;
    longint sx, sy, px, py, fx, fy, t1, t2, s;
    cvec_t  p00, p01, p10, p11, res;
    bit     right_ok;
    sw = side_of(REG_SRC_WIDTH);
    sh = side_of(REG_SRC_HEIGHT);
    dw = side_of(REG_DST_WIDTH);
    dh = side_of(REG_DST_HEIGHT);
    if (c > dw - 1) c = dw - 1;
    if (r > dh - 1) r = dh - 1;
    sx = (longint'(sw) << FRAC_BITS) / dw;
    sy = (longint'(sh) << FRAC_BITS) / dh;
    if (c == dw - 1 && r == dh - 1) begin
      // bottom-right corner copies the last source pixel
      res = pixel_at(sh - 1, sw - 1);
    end else if (c == dw - 1) begin
      // last column: vertical blend only, no offset
      py = longint'(r) * sy;
      iy = int'(py >>> FRAC_BITS);
      if (iy > sh - 1) iy = sh - 1;
      iy2 = (iy + 1 > sh - 1) ? iy : iy + 1;
      p00 = pixel_at(iy, sw - 1);
      p10 = pixel_at(iy2, sw - 1);
      for (int k = 0; k < NCH; k++) res[k] = chan_t'(lerp(p00[k], p10[k], py & FRAC_MASK));
    end else if (r == dh - 1) begin
      // last row: horizontal blend only, no offset
      px = longint'(c) * sx;
      ix = int'(px >>> FRAC_BITS);
      if (ix > sw - 1) ix = sw - 1;
      ix2 = (ix + 1 > sw - 1) ? ix : ix + 1;
      p00 = pixel_at(sh - 1, ix);
      p01 = pixel_at(sh - 1, ix2);
      for (int k = 0; k < NCH; k++) res[k] = chan_t'(lerp(p00[k], p01[k], px & FRAC_MASK));
    end else begin
      // interior: half-pixel offset clamped at zero, bilinear, then round
      py = longint'(r) * sy + (sy >>> 1) - HALF;
      px = longint'(c) * sx + (sx >>> 1) - HALF;
      if (py < 0) py = 0;
      if (px < 0) px = 0;
      iy = int'(py >>> FRAC_BITS);
      ix = int'(px >>> FRAC_BITS);
      fy = py & FRAC_MASK;
      fx = px & FRAC_MASK;
      if (iy > sh - 1) iy = sh - 1;
      if (ix > sw - 1) ix = sw - 1;
      iy2 = (iy + 1 > sh - 1) ? iy : iy + 1;
      right_ok = (ix + 1 <= sw - 1);
      p00 = pixel_at(iy, ix);
      p10 = pixel_at(iy2, ix);
      if (right_ok) begin
        p01 = pixel_at(iy, ix + 1);
        p11 = pixel_at(iy2, ix + 1);
      end
      for (int k = 0; k < NCH; k++) begin
        t1 = longint'(p00[k]) * FRAC_ONE;
        t2 = longint'(p10[k]) * FRAC_ONE;
        if (right_ok) begin
          t1 += fx * (longint'(p01[k]) - longint'(p00[k]));
          t2 += fx * (longint'(p11[k]) - longint'(p10[k]));
        end
        s = t1 * FRAC_ONE + fy * (t2 - t1);
        s = (s >>> FRAC_BITS) + HALF;
        res[k] = chan_t'(s >>> FRAC_BITS);
      end
    end
    return out_item_t'(res);
  endfunction

  // Store a write word, or queue the pixel a request word should return
  function void note_word(in_item_t w);
    if (w.kind == KIND_WRITE) begin
      frame[int'(w.row)*MAX_SIDE + int'(w.col)] = {w.red_in, w.green_in, w.blue_in};
    end else begin
      pending_pixels.push_back(resample(int'(w.col), int'(w.row)));
    end
  endfunction

  function void check_pixel(out_item_t got);
    out_item_t want;
    if (pending_pixels.size() == 0) begin
      errors++;
      $display("%0t: unexpected pixel, expected none actual %h", $time, got);
      return;
    end
    want = pending_pixels.pop_front();
    if (got.red_out !== want.red_out) begin
      errors++;
      $display("%0t: red_out expected %h actual %h", $time, want.red_out, got.red_out);
    end
    if (got.green_out !== want.green_out) begin
      errors++;
      $display("%0t: green_out expected %h actual %h", $time, want.green_out, got.green_out);
    end
    if (got.blue_out !== want.blue_out) begin
      errors++;
      $display("%0t: blue_out expected %h actual %h", $time, want.blue_out, got.blue_out);
    end
  endfunction

  function int pending();
    return pending_pixels.size();
  endfunction
endclass

module tb_rgb_bilinear_resize;

  localparam int LIMIT_CYCLES = 500000;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  in_item_t   in_item   = '0;
  logic       busy;
  logic       out_strobe;
  out_item_t  out_item;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = '0;
  cfg_data_t  cfg_data  = '0;

  bit            gaps_on = 1'b1;
  resize_checker sb      = new();

  rgb_bilinear_resize DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Check every strobed pixel against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      sb.check_pixel(out_item);
    end
  end

  // Colour byte biased towards the extremes
  function automatic chan_t any_level();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return chan_t'($urandom_range(255));
    endcase
  endfunction

  function automatic in_item_t write_at(int c, int r, chan_t rd, chan_t gr, chan_t bl);
    in_item_t w;
    w.kind     = KIND_WRITE;
    w.col      = c[IN_COORD_W-1:0];
    w.row      = r[IN_COORD_W-1:0];
    w.red_in   = rd;
    w.green_in = gr;
    w.blue_in  = bl;
    return w;
  endfunction

  function automatic in_item_t request_at(int c, int r);
    in_item_t w;
    w = write_at(c, r, any_level(), any_level(), any_level());
    w.kind = KIND_REQUEST;
    return w;
  endfunction

  // Coordinate biased towards the edges, sometimes beyond the size
  function automatic int pick_coord(int n);
    case ($urandom_range(9))
      0: return n - 1;
      1: return 0;
      2: return $urandom_range(1023);
      default: return $urandom_range(n - 1);
    endcase
  endfunction

  function automatic in_item_t random_word(int sw, int sh, int dw, int dh);
    if ($urandom_range(99) < 75) begin
      return request_at(pick_coord(dw), pick_coord(dh));
    end
    if ($urandom_range(99) < 85) begin
      return write_at($urandom_range(sw - 1), $urandom_range(sh - 1),
                      any_level(), any_level(), any_level());
    end
    return write_at($urandom_range(1023), $urandom_range(1023),
                    any_level(), any_level(), any_level());
  endfunction

  // Hold start until the word is taken, idling at random beforehand
  task automatic send_word(input in_item_t w);
    while (gaps_on && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(w);
  endtask

  // Drop start and wait for every pixel to come back, then let the block go quiet
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // Program new sizes while idle, then fill the whole source area used
  task automatic new_setting(input cfg_data_t sw_raw, input cfg_data_t sh_raw,
                             input cfg_data_t dw_raw, input cfg_data_t dh_raw,
                             input bit gaps);
    int sw, sh;
    settle();
    write_reg(REG_SRC_WIDTH, sw_raw);
    write_reg(REG_SRC_HEIGHT, sh_raw);
    write_reg(REG_DST_WIDTH, dw_raw);
    write_reg(REG_DST_HEIGHT, dh_raw);
    cfg_we  <= 1'b0;
    gaps_on  = gaps;
    sw = sb.side_of(REG_SRC_WIDTH);
    sh = sb.side_of(REG_SRC_HEIGHT);
    for (int r = 0; r < sh; r++) begin
      for (int c = 0; c < sw; c++) begin
        send_word(write_at(c, r, any_level(), any_level(), any_level()));
      end
    end
  endtask

  task automatic run_random(input int n);
    int sw, sh, dw, dh;
    sw = sb.side_of(REG_SRC_WIDTH);
    sh = sb.side_of(REG_SRC_HEIGHT);
    dw = sb.side_of(REG_DST_WIDTH);
    dh = sb.side_of(REG_DST_HEIGHT);
    for (int i = 0; i < n; i++) begin
      send_word(random_word(sw, sh, dw, dh));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 5x3 source up to 9x6, edges, corner, saturated requests
    new_setting(11'd5, 11'd3, 11'd9, 11'd6, 1'b1);
    send_word(write_at(0, 0, 8'hFF, 8'hFF, 8'hFF));
    send_word(write_at(1, 0, 8'h00, 8'h00, 8'h00));
    send_word(write_at(4, 2, 8'hFF, 8'h00, 8'hFF));
    send_word(write_at(1023, 1023, 8'hA5, 8'h5A, 8'hFF));
    send_word(request_at(0, 0));
    send_word(request_at(1, 0));
    send_word(request_at(4, 2));
    send_word(request_at(8, 0));
    send_word(request_at(8, 3));
    send_word(request_at(0, 5));
    send_word(request_at(6, 5));
    send_word(request_at(8, 5));
    send_word(request_at(7, 4));
    send_word(request_at(1023, 1));
    send_word(request_at(2, 1023));
    send_word(request_at(1023, 1023));
    send_word(request_at(5, 3));

    // Random phases through the extreme and saturated sizes
    new_setting(11'd2, 11'd2, 11'd2, 11'd2, 1'b1);
    run_random(100);
    new_setting(11'd0, 11'd1, 11'd2047, 11'd1500, 1'b1);
    run_random(120);
    new_setting(11'd1024, 11'd2, 11'd3, 11'd2, 1'b0);
    run_random(100);
    new_setting(11'd2047, 11'd2, 11'd1024, 11'd5, 1'b0);
    run_random(140);
    new_setting(11'd2, 11'd1024, 11'd7, 11'd1024, 1'b1);
    run_random(140);
    new_setting(11'd1025, 11'd3, 11'd600, 11'd2, 1'b1);
    run_random(100);
    for (int i = 0; i < 8; i++) begin
      new_setting(cfg_data_t'($urandom_range(24, 2)), cfg_data_t'($urandom_range(16, 2)),
                  cfg_data_t'($urandom_range(48, 2)), cfg_data_t'($urandom_range(48, 2)),
                  1'b1);
      run_random(130);
    end

    settle();
    if (sb.errors == 0) begin
      $display("tb_rgb_bilinear_resize: PASS");
    end else begin
      $display("tb_rgb_bilinear_resize: FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(LIMIT_CYCLES * 20);
    $display("tb_rgb_bilinear_resize: FAIL");
    $finish;
  end

endmodule
